>>> hdl/segi_pkg.sv
// shared types, widths and codes for the segment intersection block
package segi_pkg;

  localparam int COORD_W        = 16;
  localparam int OUT_W          = 20;
  localparam int CNT_OUT_W      = 9;
  localparam int BOUND_W        = 12;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 12;
  localparam int MAX_POINTS_DEF = 256;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int NEAR_PIXELS    = 15;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int MUL_W          = 19;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int ACC_W          = 36;
  localparam int NUM_W          = 53;
  localparam int LO_SPLIT       = 18;
  localparam int ENTRY_W        = 32;
  localparam logic [BOUND_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [BOUND_W-1:0] HEIGHT_RST = 12'd480;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd1;

  localparam logic CMD_TEST  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic                    in_bounds;
    logic                    stored;
    logic                    table_full;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic [CNT_OUT_W-1:0]    point_count;
  } out_item_t;

endpackage

>>> hdl/segi_mul.sv
// registered signed multiplier shared by all products
module segi_mul (
  input  logic                              clk,
  input  logic signed [segi_pkg::MUL_W-1:0] mul_a,
  input  logic signed [segi_pkg::MUL_W-1:0] mul_b,
  output logic signed [segi_pkg::PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

>>> hdl/segi_div.sv
// restoring serial divider, one quotient bit per cycle
module segi_div #(
  parameter int NW = 64,
  parameter int DW = 37
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done_r,
  output logic [NW-1:0] quo_r
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   diff;

  always_comb begin
    rem_sh = {rem_r, quo_r[NW-1]};
    ge     = rem_sh >= {1'b0, den_r};
    diff   = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

endmodule

>>> hdl/segi_ptab.sv
// point table memory, one write and one registered read port
module segi_ptab #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [segi_pkg::ENTRY_W-1:0]     wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic [segi_pkg::ENTRY_W-1:0]     rdata_r
);

  logic [segi_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> hdl/segment_intersect_dedup.sv
// top level: segment pair intersection with a table of distinct points
// a clear goes straight to the result; a miss runs the product steps and the test;
//   a hit also runs two serial divisions, x then y, and the bounds check, plus
//   a walk over the stored points when the point is inside the image
// throughput: one item at a time, set by the serial divider and the table walk
// the result register lets the next item enter while a result waits on out_stall
// reset (synchronous, rst_n low): table empty, width 640, height 480, no result pending
module segment_intersect_dedup #(
  parameter int MAX_POINTS = segi_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  segi_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output segi_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [segi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [segi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // derived widths
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW    = segi_pkg::NUM_W + FRAC_BITS + 2;
  localparam int DW    = segi_pkg::ACC_W + 1;
  localparam int PW    = NW + 1;
  localparam int CW    = ((segi_pkg::OUT_W > segi_pkg::BOUND_W + FRAC_BITS) ?
                          segi_pkg::OUT_W : segi_pkg::BOUND_W + FRAC_BITS) + 1;
  localparam int AC    = segi_pkg::ACC_W;
  localparam int NU    = segi_pkg::NUM_W;
  localparam int OW    = segi_pkg::OUT_W;
  localparam logic signed [PW-1:0] SAT_HI = PW'((2 ** (segi_pkg::OUT_W - 1)) - 1);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);
  localparam logic signed [CW-1:0] NEAR_LIM = CW'(segi_pkg::NEAR_PIXELS * (2 ** FRAC_BITS));

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_TEST  = 9'b000000100,
    ST_DIVX  = 9'b000001000,
    ST_DIVY  = 9'b000010000,
    ST_BOUND = 9'b000100000,
    ST_WALK  = 9'b001000000,
    ST_DONE  = 9'b010000000,
    ST_SPARE = 9'b100000000
  } state_t;

  // sequencer steps of the product phase
  localparam logic [3:0] STEP_LAST = 4'd11;

  state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  // operands latched per beat
  logic signed [segi_pkg::DIFF_W-1:0]  s1x_r, s1y_r, s2x_r, s2y_r, dx_r, dy_r;
  logic signed [segi_pkg::COORD_W-1:0] a0x_r, a0y_r;
  logic signed [AC-1:0] den_r, den_nxt, sn_r, sn_nxt, tn_r, tn_nxt;
  logic signed [NU-1:0] nx_r, nx_nxt, ny_r, ny_nxt;

  // result fields under construction
  logic hit_r, hit_nxt, inb_r, inb_nxt, sto_r, sto_nxt, full_r, full_nxt;
  logic signed [OW-1:0] px_r, px_nxt, py_r, py_nxt;

  logic [CNT_W-1:0] total_r, total_nxt, idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [segi_pkg::BOUND_W-1:0] width_r, height_r;
  logic             out_valid_r, out_valid_nxt;
  segi_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_acc;
  logic signed [segi_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [segi_pkg::PROD_W-1:0] prod_r;
  logic signed [AC-1:0] prod_acc;
  logic signed [NU-1:0] prod_num;

  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;
  logic [AC-1:0] den_abs;
  logic [NU-1:0] nsel_abs;
  logic signed [NU-1:0] nsel;

  logic          tab_we, tab_re;
  logic [segi_pkg::ENTRY_W-1:0] tab_rdata;
  logic signed [CW-1:0] pxe, pye, dqx, dqy, wlim, hlim;
  logic          near, walk_end, is_hit;

  function automatic logic signed [segi_pkg::DIFF_W-1:0] DIFF_EXT(
    logic signed [segi_pkg::COORD_W-1:0] v);
    return segi_pkg::DIFF_W'(v);
  endfunction

  function automatic logic ratio_ok(logic signed [AC-1:0] num, logic signed [AC-1:0] den);
    if (den > 0) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  // base point plus signed rounded quotient, saturated to the output range
  function automatic logic signed [OW-1:0] make_pt(logic signed [segi_pkg::COORD_W-1:0] a0,
                                                   logic [NW-1:0] q, logic neg);
    logic signed [PW-1:0] base;
    logic signed [PW-1:0] qs;
    logic signed [PW-1:0] sum;
    base = PW'(a0) <<< FRAC_BITS;
    qs   = signed'({1'b0, q});
    if (neg) begin
      qs = -qs;
    end
    sum = base + qs;
    if (sum > SAT_HI) begin
      sum = SAT_HI;
    end else if (sum < SAT_LO) begin
      sum = SAT_LO;
    end
    return sum[OW-1:0];
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  segi_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  segi_div #(.NW(NW), .DW(DW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  segi_ptab #(.DEPTH(MAX_POINTS), .AW(AW)) u_ptab (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (total_r[AW-1:0]),
    .wdata   ({px_r[15:0], py_r[15:0]} == '0 ? '0 : {py_r[15:0], px_r[15:0]}),
    .re      (tab_re),
    .raddr   (idx_r[AW-1:0]),
    .rdata_r (tab_rdata)
  );

  // operand select for the shared multiplier, at most one product per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      4'd0: begin mul_a = 19'(s1x_r); mul_b = 19'(s2y_r); end
      4'd1: begin mul_a = 19'(s2x_r); mul_b = 19'(s1y_r); end
      4'd2: begin mul_a = 19'(s1x_r); mul_b = 19'(dy_r); end
      4'd3: begin mul_a = 19'(s1y_r); mul_b = 19'(dx_r); end
      4'd4: begin mul_a = 19'(s2x_r); mul_b = 19'(dy_r); end
      4'd5: begin mul_a = 19'(s2y_r); mul_b = 19'(dx_r); end
      // low half of tn is unsigned, high half carries the sign
      4'd7: begin mul_a = signed'({1'b0, tn_r[segi_pkg::LO_SPLIT-1:0]});
                  mul_b = 19'(s1x_r); end
      4'd8: begin mul_a = 19'(signed'(tn_r[AC-1:segi_pkg::LO_SPLIT]));
                  mul_b = 19'(s1x_r); end
      4'd9: begin mul_a = signed'({1'b0, tn_r[segi_pkg::LO_SPLIT-1:0]});
                  mul_b = 19'(s1y_r); end
      4'd10: begin mul_a = 19'(signed'(tn_r[AC-1:segi_pkg::LO_SPLIT]));
                   mul_b = 19'(s1y_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_acc = prod_r[AC-1:0];
  assign prod_num = NU'(prod_r);

  // divider operands: x numerator while testing, y numerator after x is done
  assign nsel     = (state_r == ST_TEST) ? nx_r : ny_r;
  assign nsel_abs = nsel[NU-1] ? NU'(-nsel) : NU'(nsel);
  assign den_abs  = den_r[AC-1] ? AC'(-den_r) : AC'(den_r);
  assign div_num  = ((NW'(nsel_abs) << FRAC_BITS) << 1) + NW'(den_abs);
  assign div_den  = {den_abs, 1'b0};
  assign is_hit   = (den_r != '0) && ratio_ok(sn_r, den_r) && ratio_ok(tn_r, den_r);

  // image bounds and near test against the stored entry
  assign pxe  = CW'(px_r);
  assign pye  = CW'(py_r);
  assign wlim = signed'(CW'(width_r) << FRAC_BITS);
  assign hlim = signed'(CW'(height_r) << FRAC_BITS);
  assign dqx  = pxe - signed'(CW'(tab_rdata[15:0]));
  assign dqy  = pye - signed'(CW'(tab_rdata[31:16]));
  assign near = (dqx < NEAR_LIM) && (dqx > -NEAR_LIM) &&
                (dqy < NEAR_LIM) && (dqy > -NEAR_LIM);
  assign walk_end = !(pend_r && near) && (idx_r >= total_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    den_nxt       = den_r;
    sn_nxt        = sn_r;
    tn_nxt        = tn_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    hit_nxt       = hit_r;
    inb_nxt       = inb_r;
    sto_nxt       = sto_r;
    full_nxt      = full_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    tab_we        = 1'b0;
    tab_re        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          hit_nxt  = 1'b0;
          inb_nxt  = 1'b0;
          sto_nxt  = 1'b0;
          full_nxt = 1'b0;
          px_nxt   = '0;
          py_nxt   = '0;
          step_nxt = '0;
          if (in_data.cmd == segi_pkg::CMD_CLEAR) begin
            total_nxt = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // product issued last step lands in prod_r now
        unique case (step_r)
          4'd1:  den_nxt = prod_acc;
          4'd2:  den_nxt = den_r - prod_acc;
          4'd3:  sn_nxt  = prod_acc;
          4'd4:  sn_nxt  = sn_r - prod_acc;
          4'd5:  tn_nxt  = prod_acc;
          4'd6:  tn_nxt  = tn_r - prod_acc;
          4'd8:  nx_nxt  = prod_num;
          4'd9:  nx_nxt  = nx_r + (prod_num <<< segi_pkg::LO_SPLIT);
          4'd10: ny_nxt  = prod_num;
          4'd11: ny_nxt  = ny_r + (prod_num <<< segi_pkg::LO_SPLIT);
          default: ;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (is_hit) begin
          hit_nxt   = 1'b1;
          div_start = 1'b1;
          state_nxt = ST_DIVX;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          px_nxt    = make_pt(a0x_r, div_quo, nx_r[NU-1] ^ den_r[AC-1]);
          div_start = 1'b1;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          py_nxt    = make_pt(a0y_r, div_quo, ny_r[NU-1] ^ den_r[AC-1]);
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        idx_nxt  = '0;
        pend_nxt = 1'b0;
        if ((pxe > 0) && (pye > 0) && (pxe <= wlim) && (pye <= hlim)) begin
          inb_nxt   = 1'b1;
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        // one entry read per cycle while walking, compared once its registered read data is back
        if (pend_r && near) begin
          state_nxt = ST_DONE;
        end else if (walk_end) begin
          if (total_r < CNT_W'(MAX_POINTS)) begin
            tab_we    = 1'b1;
            total_nxt = total_r + 1'b1;
            sto_nxt   = 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          pend_nxt = idx_r < total_r;
          if (idx_r < total_r) begin
            tab_re  = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.hit         = hit_r;
          out_data_nxt.in_bounds   = inb_r;
          out_data_nxt.stored      = sto_r;
          out_data_nxt.table_full  = full_r;
          out_data_nxt.point_x     = px_r;
          out_data_nxt.point_y     = py_r;
          out_data_nxt.point_count = segi_pkg::CNT_OUT_W'(total_r);
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= segi_pkg::WIDTH_RST;
      height_r    <= segi_pkg::HEIGHT_RST;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == segi_pkg::REG_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == segi_pkg::REG_HEIGHT) begin
          height_r <= cfg_data;
        end
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1x_r <= DIFF_EXT(in_data.a_end_x) - DIFF_EXT(in_data.a_start_x);
      s1y_r <= DIFF_EXT(in_data.a_end_y) - DIFF_EXT(in_data.a_start_y);
      s2x_r <= DIFF_EXT(in_data.b_end_x) - DIFF_EXT(in_data.b_start_x);
      s2y_r <= DIFF_EXT(in_data.b_end_y) - DIFF_EXT(in_data.b_start_y);
      dx_r  <= DIFF_EXT(in_data.a_start_x) - DIFF_EXT(in_data.b_start_x);
      dy_r  <= DIFF_EXT(in_data.a_start_y) - DIFF_EXT(in_data.b_start_y);
      a0x_r <= in_data.a_start_x;
      a0y_r <= in_data.a_start_y;
    end
    den_r      <= den_nxt;
    sn_r       <= sn_nxt;
    tn_r       <= tn_nxt;
    nx_r       <= nx_nxt;
    ny_r       <= ny_nxt;
    hit_r      <= hit_nxt;
    inb_r      <= inb_nxt;
    sto_r      <= sto_nxt;
    full_r     <= full_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hdl/segi_check.sv
// port-level checker for the segment intersection block, bound to the top level
module segi_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input segi_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input segi_pkg::out_item_t             out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      !out_data.in_bounds && !out_data.stored && !out_data.table_full)
    else $error("flags set on a beat without a hit");

  a_stored_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stored |-> out_data.in_bounds && !out_data.table_full)
    else $error("stored beat is out of bounds or flagged full");

  a_full_inb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> out_data.in_bounds && out_data.hit)
    else $error("full flag without an in-bounds hit");

endmodule

bind segment_intersect_dedup segi_check u_segi_check (.*);

>>> verif/segment_intersect_dedup_tb.sv
// testbench for the segment intersection block with its table of distinct points
`timescale 1ns / 1ps

module segment_intersect_dedup_tb;

  localparam int TABLE_DEPTH = segi_pkg::MAX_POINTS_DEF;
  localparam int ONE_FIX     = 1 << segi_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  // mirror of the block: bounds, point table and the results still to come
  class crossing_model;
    logic [segi_pkg::BOUND_W-1:0] width_px;
    logic [segi_pkg::BOUND_W-1:0] height_px;
    logic [segi_pkg::ENTRY_W-1:0] points [TABLE_DEPTH];
    int                           point_total;
    segi_pkg::out_item_t          expected_points [$];
    int                           mismatches;

    function new();
      width_px    = segi_pkg::WIDTH_RST;
      height_px   = segi_pkg::HEIGHT_RST;
      point_total = 0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [segi_pkg::CFG_IDX_W-1:0] idx,
                          logic [segi_pkg::CFG_DATA_W-1:0] val);
      if (idx == segi_pkg::REG_WIDTH) width_px = val;
      else if (idx == segi_pkg::REG_HEIGHT) height_px = val;
    endfunction

    // n / d to nearest, ties away from zero
    function longint round_div(longint n, longint d);
      bit neg;
      longint unsigned an, ad, q;
      neg = (n < 0) != (d < 0);
      an  = (n < 0) ? -n : n;
      ad  = (d < 0) ? -d : d;
      q   = (2 * an + ad) / (2 * ad);
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function bit in_unit(longint num, longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
    endfunction

    function longint clip20(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
    endfunction

    function void note_segments(segi_pkg::in_item_t it);
      segi_pkg::out_item_t r;
      longint a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
      longint s1x, s1y, s2x, s2y, dx, dy, den, sn, tn, px, py, qx, qy, lim;
      bit unique_pt;
      r = '0;
      px = 0;
      py = 0;
      if (it.cmd == segi_pkg::CMD_CLEAR) begin
        point_total = 0;
      end else begin
        a0x = it.a_start_x; a0y = it.a_start_y; a1x = it.a_end_x; a1y = it.a_end_y;
        b0x = it.b_start_x; b0y = it.b_start_y; b1x = it.b_end_x; b1y = it.b_end_y;
        s1x = a1x - a0x; s1y = a1y - a0y;
        s2x = b1x - b0x; s2y = b1y - b0y;
        dx  = a0x - b0x; dy  = a0y - b0y;
        den = s1x * s2y - s2x * s1y;
        sn  = s1x * dy - s1y * dx;
        tn  = s2x * dy - s2y * dx;
        if (den != 0 && in_unit(sn, den) && in_unit(tn, den)) begin
          r.hit = 1'b1;
          px = clip20(a0x * ONE_FIX + round_div(tn * s1x * ONE_FIX, den));
          py = clip20(a0y * ONE_FIX + round_div(tn * s1y * ONE_FIX, den));
          if (px > 0 && py > 0 && px <= longint'(width_px) * ONE_FIX &&
              py <= longint'(height_px) * ONE_FIX) begin
            r.in_bounds = 1'b1;
            lim = segi_pkg::NEAR_PIXELS * ONE_FIX;
            unique_pt = 1'b1;
            for (int i = 0; i < point_total; i++) begin
              qx = points[i][15:0];
              qy = points[i][31:16];
              if ((qx > px ? qx - px : px - qx) < lim &&
                  (qy > py ? qy - py : py - qy) < lim) begin
                unique_pt = 1'b0;
                break;
              end
            end
            if (unique_pt) begin
              if (point_total < TABLE_DEPTH) begin
                points[point_total] = {py[15:0], px[15:0]};
                point_total++;
                r.stored = 1'b1;
              end else begin
                r.table_full = 1'b1;
              end
            end
          end
        end
      end
      r.point_x     = px[segi_pkg::OUT_W-1:0];
      r.point_y     = py[segi_pkg::OUT_W-1:0];
      r.point_count = point_total[segi_pkg::CNT_OUT_W-1:0];
      expected_points = {expected_points, r};
    endfunction

    function void check_result(segi_pkg::out_item_t got);
      segi_pkg::out_item_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = expected_points.pop_front();
      if (got.hit !== want.hit || got.in_bounds !== want.in_bounds ||
          got.stored !== want.stored || got.table_full !== want.table_full ||
          got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.point_count !== want.point_count) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  segi_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  segi_pkg::out_item_t             out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [segi_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [segi_pkg::CFG_DATA_W-1:0] cfg_data;

  crossing_model model = new();

  // stimulus shaping flags, set by the main sequence
  bit quiet;       // no idling on either side
  bit hold_req;    // ask the receiver for one long hold-off
  bit hold_done;
  int stall_left;
  int cycles;
  int span;        // spread of generated crossings, follows the image size

  segment_intersect_dedup DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: checks each accepted beat, then picks the stall for the next edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) model.check_result(out_data);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (hold_req && !hold_done) begin
        // long hold-off so the block fills and pushes back on its input
        hold_done  <= 1'b1;
        stall_left <= 3000;
        out_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 17);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic segi_pkg::in_item_t seg_pair(int ax0, int ay0, int ax1, int ay1,
                                                  int bx0, int by0, int bx1, int by1);
    segi_pkg::in_item_t it;
    it.cmd       = segi_pkg::CMD_TEST;
    it.a_start_x = ax0[15:0]; it.a_start_y = ay0[15:0];
    it.a_end_x   = ax1[15:0]; it.a_end_y   = ay1[15:0];
    it.b_start_x = bx0[15:0]; it.b_start_y = by0[15:0];
    it.b_end_x   = bx1[15:0]; it.b_end_y   = by1[15:0];
    return it;
  endfunction

  // small x shape centred on a whole pixel
  function automatic segi_pkg::in_item_t cross_at(int x, int y);
    return seg_pair(x - 3, y - 3, x + 3, y + 3, x - 3, y + 3, x + 3, y - 3);
  endfunction

  function automatic segi_pkg::in_item_t clear_item();
    segi_pkg::in_item_t it;
    it     = '0;
    it.cmd = segi_pkg::CMD_CLEAR;
    return it;
  endfunction

  // mostly crossings near the image with random direction and jitter,
  // some noise over the full field range and the odd clear
  function automatic segi_pkg::in_item_t random_item();
    segi_pkg::in_item_t it;
    int px, py, ux, uy, vx, vy, roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return clear_item();
    if (roll < 14) begin
      it = $bits(segi_pkg::in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.cmd = segi_pkg::CMD_TEST;
      return it;
    end
    px = $urandom_range(0, span) - 10;
    py = $urandom_range(0, span) - 10;
    ux = $urandom_range(0, 400) - 200;
    uy = $urandom_range(0, 400) - 200;
    vx = $urandom_range(0, 400) - 200;
    vy = $urandom_range(0, 400) - 200;
    return seg_pair(px - ux, py - uy, px + ux + $urandom_range(0, 2) - 1,
                    py + uy + $urandom_range(0, 2) - 1,
                    px - vx, py - vy, px + vx + $urandom_range(0, 2) - 1,
                    py + vy + $urandom_range(0, 2) - 1);
  endfunction

  // one input beat; returns at the edge that takes it
  task automatic send(segi_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    model.note_segments(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (model.expected_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [segi_pkg::CFG_IDX_W-1:0] idx,
                           logic [segi_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model.set_reg(idx, val);
  endtask

  task automatic random_run(int n);
    repeat (n) send(random_item());
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    span      = 700;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, degenerate pairs, bounds and the dedup distance
    send(clear_item());
    send(seg_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send(seg_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send(seg_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send(seg_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send(seg_pair(0, 0, 100, 0, 0, 5, 100, 5));          // parallel
    send(seg_pair(0, 0, 100, 100, 50, 50, 150, 150));    // collinear overlap
    send(seg_pair(10, 10, 20, 10, 30, 0, 30, 20));       // miss, off the end of the first segment
    send(cross_at(100, 100));                            // stored
    send(cross_at(100, 100));                            // duplicate
    send(cross_at(114, 114));                            // still inside the window
    send(cross_at(115, 100));                            // just clear on x
    send(seg_pair(200, 200, 300, 200, 200, 150, 200, 250)); // touch at segment start
    send(seg_pair(200, 300, 300, 300, 300, 250, 300, 350)); // touch at segment end
    send(cross_at(640, 480));                            // right on the corner
    send(cross_at(641, 300));                            // hit outside the image
    send(cross_at(0, 300));                              // on the left edge, outside
    send(seg_pair(0, 0, 3, 1, 0, 1, 3, 0));              // fractional point
    send(seg_pair(0, 0, -3, -1, 0, -1, -3, 0));          // negative fraction
    send(seg_pair(1, 1, 2, 2, 1, 2, 2, 1));              // crossing on a half pixel
    send(clear_item());
    send(cross_at(50, 50));
    drain();

    // fill the table on a 16 pixel grid until it overflows
    for (int k = 0; k < 270; k++) send(cross_at(8 + 16 * (k % 40), 8 + 16 * (k / 40)));
    send(clear_item());
    drain();

    // widest image, plus a write to an unused index
    write_reg(segi_pkg::REG_WIDTH, 12'd4095);
    write_reg(segi_pkg::REG_HEIGHT, 12'd4095);
    write_reg(4'd15, 12'hABC);
    span = 4200;
    random_run(300);
    drain();

    // narrowest image
    write_reg(segi_pkg::REG_WIDTH, 12'd1);
    write_reg(segi_pkg::REG_HEIGHT, 12'd1);
    span = 30;
    random_run(150);
    drain();

    // zero bounds: nothing can land inside
    write_reg(segi_pkg::REG_WIDTH, 12'd0);
    write_reg(segi_pkg::REG_HEIGHT, 12'd0);
    random_run(80);
    drain();

    // random bounds with one long receiver hold-off
    write_reg(segi_pkg::REG_WIDTH, 12'($urandom_range(1, 4095)));
    write_reg(segi_pkg::REG_HEIGHT, 12'($urandom_range(1, 4095)));
    span = (model.width_px > model.height_px ? model.width_px : model.height_px) + 40;
    hold_req = 1'b1;
    random_run(250);
    drain();

    // back to the reset bounds, no idling at all
    write_reg(segi_pkg::REG_WIDTH, segi_pkg::WIDTH_RST);
    write_reg(segi_pkg::REG_HEIGHT, segi_pkg::HEIGHT_RST);
    span  = 700;
    quiet = 1'b1;
    random_run(120);
    drain();
    repeat (300) @(posedge clk);

    if (model.mismatches == 0 && model.expected_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
